@@ sv/dsdo_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual stack package
// Sizes, state encoding and the push plan type shared by the dual stack files.
// ----------------------------------------------------------------------------
package dsdo_pkg;

   localparam int SLOT_COUNT   = 8;
   localparam int VALUE_W      = 32;
   localparam int SLOT_INDEX_W = 3;
   localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W        = $clog2(SLOT_COUNT + 1);

   localparam logic SEL_LOWER = 1'b0;
   localparam logic SEL_UPPER = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT,
      ST_REPORT
   } state_type;

   // What one push does to the store and the counts.
   typedef struct packed {
      logic             ovf;
      logic             do_shift;
      logic             shift_lower;
      logic [CNT_W-1:0] span;
      logic [IDX_W-1:0] put_addr;
      logic [CNT_W-1:0] lower_count;
      logic [CNT_W-1:0] upper_count;
   } plan_type;

endpackage

@@ sv/dsdo_channels.sv @@
// ----------------------------------------------------------------------------
// Dual stack channels
// Valid/ready interfaces for the push requests and the slot reports.
// ----------------------------------------------------------------------------
interface dsdo_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dsdo_pkg::VALUE_W-1:0] push_value;
   logic                                stack_select;

   modport source (output valid, push_value, stack_select, input ready);
   modport sink   (input valid, push_value, stack_select, output ready);
endinterface

interface dsdo_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic        [dsdo_pkg::SLOT_INDEX_W-1:0] slot_index;
   logic signed [dsdo_pkg::VALUE_W-1:0]      slot_value;
   logic                                     overflow_seen;
   logic                                     last_slot;

   modport source (output valid, slot_index, slot_value, overflow_seen, last_slot,
                   input ready);
   modport sink   (input valid, slot_index, slot_value, overflow_seen, last_slot,
                   output ready);
endinterface

@@ sv/dsdo_plan.sv @@
// ----------------------------------------------------------------------------
// Dual stack push planner
// Decides from the counts and the selector where a push lands, whether it
// drops an oldest entry, which stack shifts and what the new counts are.
// ----------------------------------------------------------------------------
module dsdo_plan (
   input  logic [dsdo_pkg::CNT_W-1:0] lower_count,
   input  logic [dsdo_pkg::CNT_W-1:0] upper_count,
   input  logic                       stack_select,
   output dsdo_pkg::plan_type         plan
);

   logic                       full;
   logic                       shift_lower;
   logic [dsdo_pkg::CNT_W-1:0] span;
   logic [dsdo_pkg::CNT_W-1:0] slot_total;
   logic [dsdo_pkg::CNT_W-1:0] one;

   assign slot_total = dsdo_pkg::CNT_W'(dsdo_pkg::SLOT_COUNT);
   assign one        = dsdo_pkg::CNT_W'(1);
   assign full       = (lower_count + upper_count) == slot_total;

   // When the pushing stack is empty the other one gives up its base entry,
   // so the shift always runs over whichever stack loses an entry.
   assign shift_lower = (stack_select == dsdo_pkg::SEL_UPPER) ?
                        (upper_count == '0) : (lower_count != '0);
   assign span        = shift_lower ? lower_count : upper_count;

   always_comb begin
      plan.ovf         = full;
      plan.shift_lower = shift_lower;
      plan.span        = span;
      plan.do_shift    = full && (span > one);
      plan.lower_count = lower_count;
      plan.upper_count = upper_count;
      if (!full) begin
         if (stack_select == dsdo_pkg::SEL_UPPER) begin
            plan.put_addr    = dsdo_pkg::IDX_W'(slot_total - one - upper_count);
            plan.upper_count = upper_count + one;
         end else begin
            plan.put_addr    = dsdo_pkg::IDX_W'(lower_count);
            plan.lower_count = lower_count + one;
         end
      end else begin
         if (shift_lower) begin
            plan.put_addr = dsdo_pkg::IDX_W'(span - one);
         end else begin
            plan.put_addr = dsdo_pkg::IDX_W'(slot_total - span);
         end
         if (stack_select == dsdo_pkg::SEL_LOWER && lower_count == '0) begin
            plan.lower_count = one;
            plan.upper_count = upper_count - one;
         end else if (stack_select == dsdo_pkg::SEL_UPPER && upper_count == '0) begin
            plan.upper_count = one;
            plan.lower_count = lower_count - one;
         end
      end
   end

endmodule

@@ sv/dual_stack_drop_oldest.sv @@
// ----------------------------------------------------------------------------
// Dual stack with drop-oldest overflow
// Two push-only stacks in one slot memory, reporting every slot after a push.
// ----------------------------------------------------------------------------
// Usage:
// Each item on req_chan pushes push_value onto the lower stack (stack_select
// 0, growing up from slot 0) or the upper stack (1, growing down from the last
// slot). A push into a full store drops the pushing stack's oldest entry, or
// the other stack's oldest when the pushing stack is empty.
// After every push, rsp_chan carries SLOT_COUNT items, slots in index order,
// with 0 for empty slots, the overflow flag and last_slot on the final one.
// One item is in work at a time: req_chan.ready is high only while idle.
// After a push is accepted, an overflow shift runs first if needed, then the
// put state writes the new value and the report reads begin. The shift moves
// the losing stack's remaining entries one slot closer to its base. The single
// read port of the slot memory is used one entry per cycle by both the shift
// and the report, the report only while the receiver is not stalling.
// A stalled receiver holds the current report in the read register; no
// further reads are issued until it is taken.
// Reset clears the counts and returns to idle. The memory is not swept:
// slots outside both stacks report as 0 from the counts, whatever they hold.
// ----------------------------------------------------------------------------
module dual_stack_drop_oldest (
   input  logic        clock,
   input  logic        reset,
   dsdo_req_if.sink    req_chan,
   dsdo_rsp_if.source  rsp_chan
);

   localparam int IDX_W = dsdo_pkg::IDX_W;
   localparam int CNT_W = dsdo_pkg::CNT_W;

   dsdo_pkg::state_type state_ff, state_in;
   dsdo_pkg::plan_type  plan;

   logic [CNT_W-1:0]                    lower_count_ff, lower_count_in;
   logic [CNT_W-1:0]                    upper_count_ff, upper_count_in;
   logic signed [dsdo_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                                ovf_ff, ovf_in;
   logic                                shift_lower_ff, shift_lower_in;
   logic [CNT_W-1:0]                    span_ff, span_in;
   logic [IDX_W-1:0]                    put_addr_ff, put_addr_in;
   logic [CNT_W-1:0]                    step_ff, step_in;
   logic                                pend_ff, pend_in;
   logic [IDX_W-1:0]                    pend_addr_ff, pend_addr_in;
   logic                                rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]                    out_idx_ff, out_idx_in;
   logic                                out_empty_ff, out_empty_in;
   logic signed [dsdo_pkg::VALUE_W-1:0] rd_data_ff;

   logic signed [dsdo_pkg::VALUE_W-1:0] mem [dsdo_pkg::SLOT_COUNT];
   logic                                mem_re;
   logic [IDX_W-1:0]                    mem_raddr;
   logic                                mem_we;
   logic [IDX_W-1:0]                    mem_waddr;
   logic signed [dsdo_pkg::VALUE_W-1:0] mem_wdata;

   logic             req_fire;
   logic             rsp_fire;
   logic             shift_done;
   logic             report_more;
   logic [IDX_W-1:0] step_idx;
   logic [IDX_W-1:0] last_idx;

   dsdo_plan u_plan (
      .lower_count  (lower_count_ff),
      .upper_count  (upper_count_ff),
      .stack_select (req_chan.stack_select),
      .plan         (plan)
   );

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign rsp_fire    = rd_valid_ff && rsp_chan.ready;
   assign step_idx    = step_ff[IDX_W-1:0];
   assign last_idx    = IDX_W'(dsdo_pkg::SLOT_COUNT - 1);
   assign shift_done  = step_ff == (span_ff - CNT_W'(1));
   assign report_more = step_ff != CNT_W'(dsdo_pkg::SLOT_COUNT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsdo_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = plan.do_shift ? dsdo_pkg::ST_SHIFT : dsdo_pkg::ST_PUT;
            end
         end
         dsdo_pkg::ST_SHIFT: begin
            if (shift_done) begin
               state_in = dsdo_pkg::ST_PUT;
            end
         end
         dsdo_pkg::ST_PUT: begin
            state_in = dsdo_pkg::ST_REPORT;
         end
         dsdo_pkg::ST_REPORT: begin
            if (rsp_fire && out_idx_ff == last_idx) begin
               state_in = dsdo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsdo_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory control and datapath.
   always_comb begin
      lower_count_in = lower_count_ff;
      upper_count_in = upper_count_ff;
      value_in       = value_ff;
      ovf_in         = ovf_ff;
      shift_lower_in = shift_lower_ff;
      span_in        = span_ff;
      put_addr_in    = put_addr_ff;
      step_in        = step_ff;
      pend_in        = 1'b0;
      pend_addr_in   = pend_addr_ff;
      rd_valid_in    = rd_valid_ff;
      out_idx_in     = out_idx_ff;
      out_empty_in   = out_empty_ff;
      mem_re         = 1'b0;
      mem_raddr      = '0;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = rd_data_ff;

      // A shift read lands in the read register and is written back from there
      // in the next cycle, one slot closer to the stack's base.
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
      end

      unique case (state_ff)
         dsdo_pkg::ST_IDLE: begin
            if (req_fire) begin
               value_in       = req_chan.push_value;
               ovf_in         = plan.ovf;
               shift_lower_in = plan.shift_lower;
               span_in        = plan.span;
               put_addr_in    = plan.put_addr;
               lower_count_in = plan.lower_count;
               upper_count_in = plan.upper_count;
               step_in        = '0;
            end
         end
         dsdo_pkg::ST_SHIFT: begin
            if (!shift_done) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               if (shift_lower_ff) begin
                  mem_raddr    = step_idx + IDX_W'(1);
                  pend_addr_in = step_idx;
               end else begin
                  mem_raddr    = IDX_W'(dsdo_pkg::SLOT_COUNT - 2) - step_idx;
                  pend_addr_in = last_idx - step_idx;
               end
               step_in = step_ff + CNT_W'(1);
            end
         end
         dsdo_pkg::ST_PUT: begin
            mem_we      = 1'b1;
            mem_waddr   = put_addr_ff;
            mem_wdata   = value_ff;
            step_in     = '0;
            rd_valid_in = 1'b0;
         end
         dsdo_pkg::ST_REPORT: begin
            if (report_more && (!rd_valid_ff || rsp_chan.ready)) begin
               mem_re       = 1'b1;
               mem_raddr    = step_idx;
               rd_valid_in  = 1'b1;
               out_idx_in   = step_idx;
               out_empty_in = (step_ff >= lower_count_ff) &&
                              (step_ff < (CNT_W'(dsdo_pkg::SLOT_COUNT) - upper_count_ff));
               step_in      = step_ff + CNT_W'(1);
            end else if (rsp_fire) begin
               rd_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dsdo_pkg::ST_IDLE;
         lower_count_ff <= '0;
         upper_count_ff <= '0;
         step_ff        <= '0;
         pend_ff        <= 1'b0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lower_count_ff <= lower_count_in;
         upper_count_ff <= upper_count_in;
         step_ff        <= step_in;
         pend_ff        <= pend_in;
         rd_valid_ff    <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      ovf_ff         <= ovf_in;
      shift_lower_ff <= shift_lower_in;
      span_ff        <= span_in;
      put_addr_ff    <= put_addr_in;
      pend_addr_ff   <= pend_addr_in;
      out_idx_ff     <= out_idx_in;
      out_empty_ff   <= out_empty_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign req_chan.ready         = state_ff == dsdo_pkg::ST_IDLE;
   assign rsp_chan.valid         = rd_valid_ff;
   assign rsp_chan.slot_index    = dsdo_pkg::SLOT_INDEX_W'(out_idx_ff);
   assign rsp_chan.slot_value    = out_empty_ff ? '0 : rd_data_ff;
   assign rsp_chan.overflow_seen = ovf_ff;
   assign rsp_chan.last_slot     = out_idx_ff == last_idx;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, lower_count_ff} + {1'b0, upper_count_ff}) <= (CNT_W + 1)'(dsdo_pkg::SLOT_COUNT))
      else $error("stack counts exceed the slot count");

   a_ovf_keeps_total: assert property (@(posedge clock) disable iff (reset)
      req_fire && plan.ovf |=> (lower_count_ff + upper_count_ff) ==
                               $past(lower_count_ff + upper_count_ff))
      else $error("overflow push changed the total entry count");

   a_report_in_state: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == dsdo_pkg::ST_REPORT)
      else $error("report item shown outside the report phase");

   a_shift_no_clash: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("shift read and write hit the same slot");

   a_shift_on_ovf: assert property (@(posedge clock) disable iff (reset)
      state_ff == dsdo_pkg::ST_SHIFT |-> ovf_ff)
      else $error("shift running without an overflow");
`endif

endmodule
